// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the draw engine fill unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("check failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("check failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("check failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/prof_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prof_pkg
// Types, constants and helpers of the rectangle and oval fill engine.
// ----------------------------------------------------------------------------
package prof_pkg;

  localparam int FB_WIDTH  = 512;
  localparam int FB_HEIGHT = 512;
  localparam int FB_DEPTH  = FB_WIDTH * FB_HEIGHT;
  localparam int ADDR_W    = $clog2(FB_DEPTH);

  localparam logic [7:0]  OP_RECT    = 8'h2A;
  localparam logic [7:0]  OP_OVAL    = 8'h2B;
  localparam logic [13:0] COUNT_MASK = 14'h3FFF;
  localparam logic [7:0]  OPC_MASK   = 8'hFF;
  localparam logic [23:0] POS_MAX    = 24'hFFFFFF;
  localparam logic [15:0] SIZE_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    OPC_STREAM  = 2'd0,
    OPC_READ    = 2'd1,
    OPC_RESTART = 2'd2
  } opc_t;

  typedef enum logic [1:0] {
    REG_STREAM_LENGTH = 2'd0,
    REG_DRAW_WIDTH    = 2'd1,
    REG_DRAW_HEIGHT   = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_HEADER, PH_X, PH_Y, PH_W, PH_H, PH_COLOR, PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_IDLE, BK_SETUP, BK_PROD, BK_RUN, BK_DRAIN, BK_READ
  } back_state_t;

  // Effective draw area.
  typedef struct packed {
    logic [9:0] w;
    logic [9:0] h;
  } area_t;

  // One command between the parser and the fill unit.
  typedef struct packed {
    logic              is_read;
    logic              read_ok;
    logic [ADDR_W-1:0] read_addr;
    logic              is_oval;
    logic [31:0]       x;
    logic [31:0]       y;
    logic [15:0]       wd;
    logic [15:0]       ht;
    logic [31:0]       color;
  } cmd_t;

  function automatic logic [9:0] eff_dim(input logic [9:0] r, input int lim);
    if (int'(r) < lim) return r;
    else return 10'(lim);
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] v);
    if (v > {16'd0, SIZE_MAX}) return SIZE_MAX;
    else return v[15:0];
  endfunction

endpackage

// ----- design/prof_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prof_queue
// Two-entry command queue between the parser and the fill unit.
// ----------------------------------------------------------------------------
module prof_queue import prof_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_cmd;
  end

endmodule

// ----- design/prof_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prof_front
// Stream parser: tracks headers, gathers shape words and queues fills and reads.
// ----------------------------------------------------------------------------
module prof_front import prof_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        enable,
  input  logic [23:0] stream_length,
  input  area_t       area,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] stream_word,
  input  logic [8:0]  read_x,
  input  logic [8:0]  read_y,
  input  logic        q_full,
  output logic        push,
  output cmd_t        push_cmd
);

  logic [23:0] pos, pos_next;
  phase_t      phase, phase_next;
  logic [13:0] skip, skip_next;
  logic        is_oval, is_oval_next;
  logic [31:0] shape_x, shape_x_next;
  logic [31:0] shape_y, shape_y_next;
  logic [15:0] shape_w, shape_w_next;
  logic [15:0] shape_h, shape_h_next;

  logic [7:0]  hdr_op;
  logic [13:0] hdr_cnt;
  logic [23:0] pos_adv;
  logic        fits;
  logic [18:0] rd_lin;

  assign in_ready = enable && !q_full;
  assign hdr_op   = stream_word[15:8] & OPC_MASK;
  assign hdr_cnt  = stream_word[29:16] & COUNT_MASK;
  assign pos_adv  = (pos == POS_MAX) ? pos : pos + 24'd1;
  assign fits     = ({1'b0, pos_adv} + 25'(hdr_cnt)) <= {1'b0, stream_length};
  assign rd_lin   = 19'(read_y) * 19'(area.w) + 19'(read_x);

  always_comb begin
    pos_next     = pos;
    phase_next   = phase;
    skip_next    = skip;
    is_oval_next = is_oval;
    shape_x_next = shape_x;
    shape_y_next = shape_y;
    shape_w_next = shape_w;
    shape_h_next = shape_h;
    push         = 1'b0;
    push_cmd     = '0;
    if (in_valid && in_ready) begin
      unique case (opc_t'(opcode))
        OPC_STREAM: begin
          unique case (phase)
            PH_HEADER: begin
              if (pos < stream_length) begin
                pos_next = pos_adv;
                if ((hdr_op == OP_RECT || hdr_op == OP_OVAL) && fits) begin
                  is_oval_next = (hdr_op == OP_OVAL);
                  phase_next   = PH_X;
                end else if (hdr_cnt != 14'd0) begin
                  skip_next  = hdr_cnt;
                  phase_next = PH_SKIP;
                end
              end
            end
            PH_X: begin
              shape_x_next = stream_word;
              phase_next   = PH_Y;
              pos_next     = pos_adv;
            end
            PH_Y: begin
              shape_y_next = stream_word;
              phase_next   = PH_W;
              pos_next     = pos_adv;
            end
            PH_W: begin
              shape_w_next = sat16(stream_word);
              phase_next   = PH_H;
              pos_next     = pos_adv;
            end
            PH_H: begin
              shape_h_next = sat16(stream_word);
              phase_next   = PH_COLOR;
              pos_next     = pos_adv;
            end
            PH_COLOR: begin
              push             = 1'b1;
              push_cmd.is_oval = is_oval;
              push_cmd.x       = shape_x;
              push_cmd.y       = shape_y;
              push_cmd.wd      = shape_w;
              push_cmd.ht      = shape_h;
              push_cmd.color   = stream_word;
              phase_next       = PH_HEADER;
              pos_next         = pos_adv;
            end
            PH_SKIP: begin
              if (skip <= 14'd1) begin
                skip_next  = 14'd0;
                phase_next = PH_HEADER;
              end else begin
                skip_next = skip - 14'd1;
              end
              pos_next = pos_adv;
            end
            default: phase_next = PH_HEADER;
          endcase
        end
        OPC_READ: begin
          push               = 1'b1;
          push_cmd.is_read   = 1'b1;
          push_cmd.read_ok   = ({1'b0, read_x} < area.w) && ({1'b0, read_y} < area.h);
          push_cmd.read_addr = ADDR_W'(rd_lin);
        end
        OPC_RESTART: begin
          pos_next   = 24'd0;
          phase_next = PH_HEADER;
          skip_next  = 14'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= 24'd0;
      phase   <= PH_HEADER;
      skip    <= 14'd0;
      is_oval <= 1'b0;
      shape_x <= 32'd0;
      shape_y <= 32'd0;
      shape_w <= 16'd0;
      shape_h <= 16'd0;
    end else begin
      pos     <= pos_next;
      phase   <= phase_next;
      skip    <= skip_next;
      is_oval <= is_oval_next;
      shape_x <= shape_x_next;
      shape_y <= shape_y_next;
      shape_w <= shape_w_next;
      shape_h <= shape_h_next;
    end
  end

endmodule

// ----- design/prof_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// prof_back
// Fill unit: clears the frame store, scans and fills shapes, serves reads.
// ----------------------------------------------------------------------------
module prof_back import prof_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  area_t       area,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        clear_done,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_value
);

  back_state_t state, state_next;

  logic [31:0] mem [FB_DEPTH];
  logic [31:0] rdata;
  logic        re;
  logic        we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0] wdata;

  logic [ADDR_W-1:0] clr_addr;
  cmd_t        cur;
  logic        rd_ok;
  logic [31:0] wd2, ht2;
  logic [63:0] total;
  logic [9:0]  x_end, y_end;
  logic        empty;
  logic [9:0]  px, py;
  logic [ADDR_W-1:0] row_base;

  // Pixel pipeline: offsets, squares, scaled squares, then the write.
  logic              p1_v, p2_v, p3_v;
  logic [15:0]       p1_a, p1_b;
  logic [ADDR_W-1:0] p1_addr, p2_addr, p3_addr;
  logic [31:0]       p2_a2, p2_b2;
  logic [63:0]       p3_ta, p3_tb;

  logic [32:0] xs, ys;
  logic [9:0]  u, v;
  logic [17:0] da, db;
  logic        last_col, last_row;
  logic        in_shape;

  assign clear_done = (state != BK_CLEAR);
  assign xs = {1'b0, cur.x} + 33'(cur.wd);
  assign ys = {1'b0, cur.y} + 33'(cur.ht);
  assign u  = px - cur.x[9:0];
  assign v  = py - cur.y[9:0];
  assign da = {7'd0, u, 1'b0} - {2'd0, cur.wd};
  assign db = {7'd0, v, 1'b0} - {2'd0, cur.ht};
  assign last_col = ({1'b0, px} + 11'd1) == {1'b0, x_end};
  assign last_row = ({1'b0, py} + 11'd1) == {1'b0, y_end};
  assign in_shape = !cur.is_oval || (({1'b0, p3_ta} + {1'b0, p3_tb}) <= {1'b0, total});

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    re         = 1'b0;
    unique case (state)
      BK_CLEAR: if (clr_addr == ADDR_W'(FB_DEPTH - 1)) state_next = BK_IDLE;
      BK_IDLE: begin
        if (!q_empty) begin
          if (!q_head.is_read) begin
            q_pop      = 1'b1;
            state_next = BK_SETUP;
          end else if (!out_valid) begin
            q_pop      = 1'b1;
            re         = 1'b1;
            state_next = BK_READ;
          end
        end
      end
      BK_SETUP: state_next = BK_PROD;
      BK_PROD:  state_next = empty ? BK_IDLE : BK_RUN;
      BK_RUN:   if (last_col && last_row) state_next = BK_DRAIN;
      BK_DRAIN: if (!p1_v && !p2_v && !p3_v) state_next = BK_IDLE;
      BK_READ:  state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    if (state == BK_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = 32'd0;
    end else begin
      we    = p3_v && in_shape;
      waddr = p3_addr;
      wdata = cur.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      p3_v      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (state == BK_READ) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      p1_v <= (state == BK_RUN);
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[q_head.read_addr];
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && q_pop) begin
      cur   <= q_head;
      rd_ok <= q_head.read_ok;
    end
    if (state == BK_READ) pixel_value <= rd_ok ? rdata : 32'd0;
    if (state == BK_SETUP) begin
      wd2      <= 32'(cur.wd) * 32'(cur.wd);
      ht2      <= 32'(cur.ht) * 32'(cur.ht);
      x_end    <= (xs > 33'(area.w)) ? area.w : xs[9:0];
      y_end    <= (ys > 33'(area.h)) ? area.h : ys[9:0];
      empty    <= (33'(cur.x) >= xs) || (33'(cur.x) >= 33'(area.w)) ||
                  (33'(cur.y) >= ys) || (33'(cur.y) >= 33'(area.h)) ||
                  (cur.is_oval && (cur.wd == 16'd0 || cur.ht == 16'd0));
      px       <= cur.x[9:0];
      py       <= cur.y[9:0];
      row_base <= ADDR_W'(20'(cur.y[9:0]) * 20'(area.w));
    end
    if (state == BK_PROD) total <= 64'(wd2) * 64'(ht2);
    if (state == BK_RUN) begin
      p1_a    <= da[17] ? 16'(-da) : da[15:0];
      p1_b    <= db[17] ? 16'(-db) : db[15:0];
      p1_addr <= row_base + ADDR_W'(px);
      if (last_col) begin
        px       <= cur.x[9:0];
        py       <= py + 10'd1;
        row_base <= row_base + ADDR_W'(area.w);
      end else begin
        px <= px + 10'd1;
      end
    end
    p2_a2   <= 32'(p1_a) * 32'(p1_a);
    p2_b2   <= 32'(p1_b) * 32'(p1_b);
    p2_addr <= p1_addr;
    p3_ta   <= 64'(p2_a2) * 64'(ht2);
    p3_tb   <= 64'(p2_b2) * 64'(wd2);
    p3_addr <= p2_addr;
  end

  `ASSERT_IMPLIES(a_no_pop_in_clear, state == BK_CLEAR, !q_pop)
  `ASSERT_IMPLIES(a_read_slot_free, state == BK_READ, !out_valid)
  `ASSERT_IMPLIES(a_pipe_only_in_fill, p3_v, state == BK_RUN || state == BK_DRAIN)

endmodule

// ----- design/packet_rect_oval_fill.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_rect_oval_fill
// Command stream parser with rectangle and oval fill into a 512x512 store.
// ----------------------------------------------------------------------------
// After reset the frame store is swept to zero, one pixel a cycle, over all
// FB_WIDTH * FB_HEIGHT addresses; no word is accepted until it ends,
// while register writes are taken at any time. Stream words are then taken
// one a cycle; a color word or a read goes into a two-entry command queue and
// waits when it is full. The fill unit passes its setup states BK_SETUP and
// BK_PROD, fills one pixel per cycle of the clipped bounding box, and drains
// its pixel pipeline; a read is served from the frame store read port. The
// result register frees the fill unit while a read word waits to be taken.
module packet_rect_oval_fill import prof_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] stream_word,
  input  logic [8:0]  read_x,
  input  logic [8:0]  read_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_value
);

  logic [23:0] stream_length;
  logic [9:0]  draw_width;
  logic [9:0]  draw_height;
  area_t       area;
  logic        clear_done;
  logic        q_push, q_full, q_pop, q_empty;
  cmd_t        q_in, q_head;

  assign cfg_ready = 1'b1;
  assign area.w = eff_dim(draw_width, FB_WIDTH);
  assign area.h = eff_dim(draw_height, FB_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_length <= 24'd0;
      draw_width    <= 10'd512;
      draw_height   <= 10'd512;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_STREAM_LENGTH: stream_length <= cfg_data;
        REG_DRAW_WIDTH:    draw_width    <= cfg_data[9:0];
        REG_DRAW_HEIGHT:   draw_height   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  prof_front u_front (
    .clk           (clk),
    .rst           (rst),
    .enable        (clear_done),
    .stream_length (stream_length),
    .area          (area),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .stream_word   (stream_word),
    .read_x        (read_x),
    .read_y        (read_y),
    .q_full        (q_full),
    .push          (q_push),
    .push_cmd      (q_in)
  );

  prof_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  prof_back u_back (
    .clk         (clk),
    .rst         (rst),
    .area        (area),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .clear_done  (clear_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_value (pixel_value)
  );

endmodule

// ----- verif/pixel_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_checker
// Watches the register, word and pixel channels of the fill engine, keeps its
// own copy of the parser state and the frame store, and compares every pixel
// read result with the color that the store should hold.
// ----------------------------------------------------------------------------
module pixel_checker import prof_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] stream_word,
  input  logic [8:0]  read_x,
  input  logic [8:0]  read_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] pixel_value,
  output int          errors,
  output int          pending
);

  logic [23:0] len_q;
  logic [9:0]  dw_q, dh_q;
  logic [23:0] pos_q;
  phase_t      phase_q;
  logic [13:0] skip_q;
  logic        oval_q;
  logic [31:0] sx_q, sy_q;
  logic [15:0] swd_q, sht_q;
  logic [31:0] pixels [FB_DEPTH];
  logic [31:0] colors_due [$];

  function automatic longint unsigned clip_w();
    return (dw_q > FB_WIDTH) ? FB_WIDTH : dw_q;
  endfunction

  function automatic longint unsigned clip_h();
    return (dh_q > FB_HEIGHT) ? FB_HEIGHT : dh_q;
  endfunction

  function automatic bit inside_oval(longint unsigned u, longint unsigned v,
                                     longint unsigned wd, longint unsigned ht);
    longint unsigned a, b, whole, ta, tb;
    a = (2 * u >= wd) ? 2 * u - wd : wd - 2 * u;
    b = (2 * v >= ht) ? 2 * v - ht : ht - 2 * v;
    whole = wd * wd * ht * ht;
    ta = a * a * ht * ht;
    tb = b * b * wd * wd;
    return ta <= whole && tb <= whole - ta;
  endfunction

  task automatic paint(input logic [31:0] color);
    longint unsigned w, h, xe, ye, px, py;
    w = clip_w();
    h = clip_h();
    xe = longint'(sx_q) + swd_q;
    ye = longint'(sy_q) + sht_q;
    if (xe > w) xe = w;
    if (ye > h) ye = h;
    if (oval_q && (swd_q == 0 || sht_q == 0)) return;
    for (py = sy_q; py < ye; py++)
      for (px = sx_q; px < xe; px++)
        if (!oval_q || inside_oval(px - sx_q, py - sy_q, swd_q, sht_q))
          pixels[py * w + px] = color;
  endtask

  task automatic bump_pos();
    if (pos_q != POS_MAX) pos_q++;
  endtask

  task automatic take_word(input logic [31:0] word);
    logic [7:0]  op;
    logic [13:0] cnt;
    case (phase_q)
      PH_HEADER: begin
        if (pos_q >= len_q) return;
        op = word[15:8];
        cnt = word[29:16];
        bump_pos();
        if ((op == OP_RECT || op == OP_OVAL) && 25'(pos_q) + cnt <= 25'(len_q)) begin
          oval_q = (op == OP_OVAL);
          phase_q = PH_X;
        end else if (cnt != 0) begin
          skip_q = cnt;
          phase_q = PH_SKIP;
        end
        return;
      end
      PH_X: begin sx_q = word; phase_q = PH_Y; end
      PH_Y: begin sy_q = word; phase_q = PH_W; end
      PH_W: begin swd_q = sat16(word); phase_q = PH_H; end
      PH_H: begin sht_q = sat16(word); phase_q = PH_COLOR; end
      PH_COLOR: begin paint(word); phase_q = PH_HEADER; end
      PH_SKIP: begin
        if (skip_q != 0) skip_q--;
        if (skip_q == 0) phase_q = PH_HEADER;
      end
      default: begin phase_q = PH_HEADER; return; end
    endcase
    bump_pos();
  endtask

  initial begin
    errors = 0;
    pending = 0;
    for (int i = 0; i < FB_DEPTH; i++) pixels[i] = '0;
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      len_q <= '0;
      dw_q <= 10'd512;
      dh_q <= 10'd512;
      pos_q <= '0;
      phase_q <= PH_HEADER;
      skip_q <= '0;
      oval_q <= 1'b0;
      sx_q <= '0;
      sy_q <= '0;
      swd_q <= '0;
      sht_q <= '0;
    end else begin
      if (out_valid && out_ready) begin
        if (colors_due.size() == 0) begin
          $display("%0t: unexpected pixel word, expected none, actual %h",
                   $time, pixel_value);
          errors++;
        end else begin
          want = colors_due.pop_front();
          if (pixel_value !== want) begin
            $display("%0t: pixel_value expected %h actual %h", $time, want, pixel_value);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_STREAM_LENGTH: len_q = cfg_data;
          REG_DRAW_WIDTH:    dw_q = cfg_data[9:0];
          REG_DRAW_HEIGHT:   dh_q = cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (opc_t'(opcode))
          OPC_STREAM: take_word(stream_word);
          OPC_READ: begin
            if (read_x < clip_w() && read_y < clip_h())
              colors_due.push_back(pixels[longint'(read_y) * clip_w() + read_x]);
            else
              colors_due.push_back('0);
          end
          OPC_RESTART: begin
            pos_q = '0;
            phase_q = PH_HEADER;
            skip_q = '0;
          end
          default: ;
        endcase
      end
    end
    pending <= colors_due.size();
  end

endmodule

// ----- verif/tb_packet_rect_oval_fill.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_rect_oval_fill
// Drives command streams, register settings and pixel reads into the fill
// engine under random back pressure; the checker predicts every read.
// ----------------------------------------------------------------------------
module tb_packet_rect_oval_fill;
  import prof_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int RAND_WORDS  = 1150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [31:0] stream_word = '0;
  logic [8:0]  read_x = '0;
  logic [8:0]  read_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pixel_value;
  int          errors, pending;
  int          cycles = 0;
  int          words_sent = 0;
  bit          calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  packet_rect_oval_fill u_top (.*);

  pixel_checker u_check (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= calm || ($urandom_range(99) >= 16);

  task automatic send(input opc_t opc, input logic [31:0] word,
                      input logic [8:0] rx, input logic [8:0] ry);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    opcode <= opc;
    stream_word <= word;
    read_x <= rx;
    read_y <= ry;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic put(input logic [31:0] word);
    send(OPC_STREAM, word, 9'($urandom), 9'($urandom));
  endtask

  task automatic read_pixel(input logic [8:0] rx, input logic [8:0] ry);
    send(OPC_READ, $urandom, rx, ry);
  endtask

  function automatic logic [31:0] header(input logic [7:0] op, input logic [13:0] cnt);
    return {2'($urandom), cnt, op, 8'($urandom)};
  endfunction

  task automatic shape(input bit oval, input logic [31:0] x, input logic [31:0] y,
                       input logic [31:0] w, input logic [31:0] h, input logic [31:0] c);
    put(header(oval ? OP_OVAL : OP_RECT, 14'd5));
    put(x);
    put(y);
    put(w);
    put(h);
    put(c);
  endtask

  // A read queues behind any fill in progress, so its result marks the
  // engine idle before the registers change.
  task automatic settle();
    read_pixel(9'($urandom), 9'($urandom));
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [23:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_packet();
    int pick, n;
    logic [31:0] x, y, w, h;
    pick = $urandom_range(99);
    if (pick < 65) begin
      x = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 60);
      y = ($urandom_range(9) == 0) ? $urandom_range(500, 511) : $urandom_range(0, 60);
      w = $urandom_range(0, 14);
      h = $urandom_range(0, 14);
      if ($urandom_range(7) == 0) begin
        w = $urandom;
        h = $urandom_range(0, 3);
      end
      put(header($urandom_range(1) ? OP_OVAL : OP_RECT, 14'($urandom_range(0, 6))));
      put(x);
      put(y);
      if ($urandom_range(19) == 0) begin
        send(OPC_RESTART, $urandom, 9'($urandom), 9'($urandom));
        return;
      end
      put(w);
      put(h);
      put($urandom);
    end else if (pick < 78) begin
      n = ($urandom_range(29) == 0) ? 14'h3FFF : $urandom_range(0, 5);
      put(header(8'($urandom), 14'(n)));
      repeat ((n > 6) ? 6 : n) put($urandom);
    end else if (pick < 93) begin
      if ($urandom_range(3) == 0) read_pixel(9'($urandom), 9'($urandom));
      else read_pixel(9'($urandom_range(0, 70)), 9'($urandom_range(0, 70)));
    end else if (pick < 97) begin
      send(OPC_RESTART, $urandom, 9'($urandom), 9'($urandom));
    end else if (pick < 99) begin
      send(opc_t'(2'd3), $urandom, 9'($urandom), 9'($urandom));
    end else begin
      put($urandom);
    end
  endtask

  initial begin
    logic [23:0] lens [6] = '{24'd100000, 24'hFFFFFF, 24'd40, 24'd100000, 24'd100000, 24'd5000};
    logic [23:0] wids [6] = '{24'd512, 24'd1023, 24'd300, 24'd1, 24'd0, 24'd512};
    logic [23:0] hgts [6] = '{24'd512, 24'd1023, 24'd200, 24'd1, 24'd512, 24'd1};
    int goal;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Stream length is zero after reset, so this header is dropped.
    read_pixel(9'd0, 9'd0);
    read_pixel(9'd511, 9'd511);
    shape(1'b0, 32'd1, 32'd1, 32'd4, 32'd4, 32'h12345678);
    read_pixel(9'd2, 9'd2);
    settle();
    write_reg(REG_STREAM_LENGTH, 24'd200);
    write_reg(REG_DRAW_WIDTH, 24'd512);
    write_reg(REG_DRAW_HEIGHT, 24'd512);

    shape(1'b0, 32'd0, 32'd0, 32'd512, 32'd512, 32'hFFFFFFFF);
    shape(1'b0, 32'd3, 32'd4, 32'd6, 32'd5, 32'h0);
    read_pixel(9'd5, 9'd6);
    shape(1'b1, 32'd0, 32'd0, 32'd20, 32'd11, 32'hA5A5A5A5);
    read_pixel(9'd0, 9'd5);
    read_pixel(9'd10, 9'd0);
    shape(1'b1, 32'd30, 32'd30, 32'd0, 32'd8, 32'h5A5A5A5A);
    shape(1'b0, 32'd500, 32'd505, 32'hFFFFFFFF, 32'd100000, 32'h00C0FFEE);
    read_pixel(9'd511, 9'd511);
    put(header(8'h11, 14'd2));
    put($urandom);
    put($urandom);
    put(header(8'h00, 14'd0));
    // Draw header whose count overruns the stream becomes a skip.
    put(header(OP_RECT, 14'h3FFF));
    send(OPC_RESTART, $urandom, 9'($urandom), 9'($urandom));
    send(opc_t'(2'd3), $urandom, 9'($urandom), 9'($urandom));
    read_pixel(9'd30, 9'd32);

    goal = words_sent;
    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(REG_STREAM_LENGTH, lens[p]);
      write_reg(REG_DRAW_WIDTH, wids[p]);
      write_reg(REG_DRAW_HEIGHT, hgts[p]);
      calm = (p == 1);
      goal += RAND_WORDS / 6;
      while (words_sent < goal) random_packet();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
